// ----- rtl/core/signed_binary_to_decimal_ascii_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed binary to decimal ASCII converter
// Implication checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication
`define SBDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sbda_pkg.sv -----
// ----------------------------------------------------------------------------
// sbda_pkg
// Widths, ASCII codes and sequencer codes for the decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned CharWidth   = 8;
  localparam int unsigned NumDigits   = 20;
  localparam int unsigned BcdWidth    = 4 * NumDigits;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned DigCntWidth = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] AsciiZero  = 8'd48;
  localparam logic [CharWidth-1:0] AsciiMinus = 8'd45;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;

endpackage

// ----- rtl/core/signed_binary_to_decimal_ascii_top.sv -----
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_top
// Converts a signed 64-bit integer to decimal ASCII text, one character per
// result, sign first, no leading zeros, last flag on the final digit.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  handshake
//  command   start_i, value_i, busy_o         in         start_i & !busy_o
//  result    char_valid_o, char_code_o,       out        char_valid_o strobe
//            last_char_o
//
//  Each number is converted by bit-serial double dabble into 20 BCD
//  digits; leading zeros are then dropped one digit at a time, and the
//  remaining digits are emitted as characters, most significant first.
//  The '-' is emitted in the cycle after accept, during conversion.
//  busy_o is high from accept until the last character is registered.
//  Reset clears the sequencer and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_top_defines.svh"

module signed_binary_to_decimal_ascii_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sbda_pkg::ValueWidth-1:0] value_i,
  output logic                                busy_o,
  output logic                                char_valid_o,
  output logic [sbda_pkg::CharWidth-1:0]      char_code_o,
  output logic                                last_char_o
);

  logic [2:0]                          state_q, state_d;
  logic [sbda_pkg::ValueWidth-1:0]     mag_q, mag_d;
  logic [sbda_pkg::BcdWidth-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [sbda_pkg::BitCntWidth-1:0]    bit_cnt_q, bit_cnt_d;
  logic [sbda_pkg::DigCntWidth-1:0]    dig_cnt_q, dig_cnt_d;
  logic                                valid_q, valid_d;
  logic [sbda_pkg::CharWidth-1:0]      char_q, char_d;
  logic                                last_q, last_d;
  logic                                accept;
  logic [3:0]                          top_dig;

  assign accept  = start_i && (state_q == sbda_pkg::StIdle);
  assign top_dig = bcd_q[sbda_pkg::BcdWidth-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sbda_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    unique case (state_q)
      sbda_pkg::StIdle: begin
        if (accept) begin
          mag_d     = value_i[sbda_pkg::ValueWidth-1] ? -value_i : value_i;
          bcd_d     = '0;
          bit_cnt_d = '1;
          dig_cnt_d = sbda_pkg::DigCntWidth'(sbda_pkg::NumDigits);
          state_d   = sbda_pkg::StConv;
          if (value_i[sbda_pkg::ValueWidth-1]) begin
            valid_d = 1'b1;
            char_d  = sbda_pkg::AsciiMinus;
            last_d  = 1'b0;
          end
        end
      end
      sbda_pkg::StConv: begin
        bcd_d     = {bcd_adj[sbda_pkg::BcdWidth-2:0], mag_q[sbda_pkg::ValueWidth-1]};
        mag_d     = {mag_q[sbda_pkg::ValueWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = sbda_pkg::StSkip;
        end
      end
      sbda_pkg::StSkip: begin
        if (top_dig == 4'd0 && dig_cnt_q != sbda_pkg::DigCntWidth'(1)) begin
          bcd_d     = {bcd_q[sbda_pkg::BcdWidth-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else begin
          state_d = sbda_pkg::StEmit;
        end
      end
      sbda_pkg::StEmit: begin
        valid_d   = 1'b1;
        char_d    = sbda_pkg::AsciiZero | {4'd0, top_dig};
        last_d    = (dig_cnt_q == sbda_pkg::DigCntWidth'(1));
        bcd_d     = {bcd_q[sbda_pkg::BcdWidth-5:0], 4'd0};
        dig_cnt_d = dig_cnt_q - 1'b1;
        if (dig_cnt_q == sbda_pkg::DigCntWidth'(1)) begin
          state_d = sbda_pkg::StIdle;
        end
      end
      default: begin
        state_d = sbda_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbda_pkg::StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign busy_o       = (state_q != sbda_pkg::StIdle);
  assign char_valid_o = valid_q;
  assign char_code_o  = char_q;
  assign last_char_o  = last_q;

  `SBDA_ASSERT_NXT(a_accept_busy, accept, busy_o, "accepted transaction did not raise busy")
  `SBDA_ASSERT_IMP(a_emit_count, state_q == sbda_pkg::StEmit, dig_cnt_q != '0,
                   "emitting with no digits left")
  `SBDA_ASSERT_IMP(a_last_digit, char_valid_o && last_char_o,
                   char_code_o != sbda_pkg::AsciiMinus, "sign flagged as last character")

endmodule
